// ===== sv/ord_pkg.sv =====
// Package: constants, config register indexes and shared types for the obstacle report decider.
package ord_pkg;

  localparam int unsigned DistW   = 16;
  localparam int unsigned StrW    = 16;
  localparam int unsigned ThrW    = 11;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 11;

  localparam logic [StrW-1:0]   StrengthLow  = 16'd20;
  localparam logic [StrW-1:0]   StrengthHigh = 16'd2000;
  localparam logic [DistW-1:0]  FarDist      = 16'd1200;
  localparam logic [DistW-1:0]  Band800      = 16'd800;
  localparam logic [DistW-1:0]  Band500      = 16'd500;
  localparam logic [DistW-1:0]  Band100      = 16'd100;
  localparam logic [CountW-1:0] CountTop     = 8'd255;

  localparam logic [ThrW-1:0]   NearThrReset = 11'd500;
  localparam logic [CountW-1:0] BurstReset   = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNearThr    = 1'b0,
    CfgBurstLimit = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [StrW-1:0]  strength;
  } reading_t;

endpackage

// ===== sv/ord_if.sv =====
// Interfaces: reading request channel and report result channel.
interface ord_in_if;
  import ord_pkg::*;
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  logic [StrW-1:0]  strength;

  modport source (output valid, distance, strength, input ready);
  modport sink (input valid, distance, strength, output ready);
endinterface

interface ord_out_if;
  logic valid;
  logic ready;
  logic send_report;
  logic obstacle_flag;
  logic reading_accepted;

  modport source (output valid, send_report, obstacle_flag, reading_accepted, input ready);
  modport sink (input valid, send_report, obstacle_flag, reading_accepted, output ready);
endinterface

// ===== sv/ord_report_rule.sv =====
// Report rule: burst limit and distance-banded count modulo checks.
module ord_report_rule import ord_pkg::*; (
  input  logic [DistW-1:0]  distance_i,
  input  logic [CountW-1:0] count_i,
  input  logic [CountW-1:0] burst_limit_i,
  output logic              due_o
);

  logic [15:0] p3, p5;
  logic [6:0]  q3;
  logic [5:0]  q5;
  logic [4:0]  q10;
  logic        m3, m5, m10;
  logic        band_far, band_mid, band_near, band_close;

  // reciprocal multiply, exact for 8-bit counts
  assign p3  = 16'(count_i) * 16'd171;
  assign p5  = 16'(count_i) * 16'd205;
  assign q3  = p3[15:9];
  assign q5  = p5[15:10];
  assign q10 = p5[15:11];

  assign m3  = (8'(q3) * 8'd3) == count_i;
  assign m5  = (8'(q5) * 8'd5) == count_i;
  assign m10 = (8'(q10) * 8'd10) == count_i;

  assign band_far   = (distance_i > Band800) && (distance_i < FarDist);
  assign band_mid   = (distance_i > Band500) && (distance_i <= Band800);
  assign band_near  = (distance_i > Band100) && (distance_i < Band500);
  assign band_close = (distance_i <= Band100);

  assign due_o = (count_i < burst_limit_i) || (band_far && m10) || (band_mid && m5) ||
                 (band_near && m3) || band_close;

endmodule

// ===== sv/obstacle_report_decider.sv =====
// Top level: obstacle report decider with input register and result register.
// Data path: an accepted reading waits in the input register and moves into the
//   result register when that register is empty or its result is being taken.
// Throughput: one reading per cycle unless res_o.ready holds the result back.
// Reset: async active low; history, fill, counter, flag and valids clear,
//   near_threshold returns to 500 and burst_limit to 3.
module obstacle_report_decider import ord_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ord_in_if.sink              req_i,
  ord_out_if.source           res_o
);

  logic [ThrW-1:0]   near_thr_q;
  logic [CountW-1:0] burst_limit_q;

  logic              s1_valid_q;
  reading_t          s1_q;

  logic [DistW-1:0]  r0_q, r1_q, r0_d, r1_d;
  logic [1:0]        fill_q, fill_d;
  logic [CountW-1:0] count_q, count_d, count_inc, count_step;
  logic              held_q, held_d;

  logic              out_valid_q;
  logic              send_q, flag_q, acc_q;

  logic              adv;
  logic              accepted, declining, near, fire, due, send;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q    <= NearThrReset;
      burst_limit_q <= BurstReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgNearThr:    near_thr_q    <= cfg_wdata_i[ThrW-1:0];
        CfgBurstLimit: burst_limit_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q.distance <= req_i.distance;
      s1_q.strength <= req_i.strength;
    end
  end

  ord_report_rule u_rule (
    .distance_i    (s1_q.distance),
    .count_i       (count_q),
    .burst_limit_i (burst_limit_q),
    .due_o         (due)
  );

  assign accepted   = (s1_q.strength >= StrengthLow) && (s1_q.strength <= StrengthHigh);
  assign declining  = fill_q[1] && (s1_q.distance < r0_q) && (r0_q < r1_q);
  assign near       = s1_q.distance < FarDist;
  assign fire       = near && (s1_q.distance < DistW'(near_thr_q)) && declining;
  assign send       = accepted && fire && due;
  assign count_inc  = count_q + 8'd1;
  assign count_step = (count_inc == CountTop) ? burst_limit_q : count_inc;

  always_comb begin
    r0_d    = r0_q;
    r1_d    = r1_q;
    fill_d  = fill_q;
    count_d = count_q;
    held_d  = held_q;
    if (accepted) begin
      r1_d = r0_q;
      r0_d = s1_q.distance;
      if (!fill_q[1]) begin
        fill_d = fill_q + 2'd1;
      end
      if (near) begin
        if (fire) begin
          held_d  = 1'b1;
          count_d = count_step;
        end
      end else begin
        held_d  = 1'b0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q    <= '0;
      r1_q    <= '0;
      fill_q  <= '0;
      count_q <= '0;
      held_q  <= 1'b0;
    end else if (adv) begin
      r0_q    <= r0_d;
      r1_q    <= r1_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      send_q <= send;
      flag_q <= held_d;
      acc_q  <= accepted;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.send_report      = send_q;
  assign res_o.obstacle_flag    = flag_q;
  assign res_o.reading_accepted = acc_q;

endmodule

// ===== sv/ord_checker.sv =====
// Checker: port-level properties of the obstacle report decider, bound to the top level.
module ord_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic send_report_i,
  input logic obstacle_flag_i,
  input logic reading_accepted_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(send_report_i) && $stable(obstacle_flag_i) && $stable(reading_accepted_i))
    else $error("result payload changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 out_valid_i)
    else $error("no result two cycles after request");

  a_send_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_report_i |-> obstacle_flag_i && reading_accepted_i)
    else $error("report without flag or accepted reading");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind obstacle_report_decider ord_checker u_ord_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (req_i.valid),
  .in_ready_i         (req_i.ready),
  .out_valid_i        (res_o.valid),
  .out_ready_i        (res_o.ready),
  .send_report_i      (res_o.send_report),
  .obstacle_flag_i    (res_o.obstacle_flag),
  .reading_accepted_i (res_o.reading_accepted)
);

// ===== sim/obstacle_report_decider_test.sv =====
// Testbench for the obstacle report decider: directed and random readings checked against a predictor.
`timescale 1ns / 100ps

module obstacle_report_decider_test;
  import ord_pkg::*;

  localparam int unsigned QuietLimit = 1000;

  typedef struct packed {
    logic send_report;
    logic obstacle_flag;
    logic reading_accepted;
  } decision_t;

  typedef enum int unsigned {
    RxSteady,
    RxRandom,
    RxPattern
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ord_in_if  req_if ();
  ord_out_if res_if ();

  obstacle_report_decider i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state, mirrors the block after reset
  logic [ThrW-1:0]   thr_cfg     = NearThrReset;
  logic [CountW-1:0] burst_cfg   = BurstReset;
  logic [DistW-1:0]  hist_newest = '0;
  logic [DistW-1:0]  hist_prev   = '0;
  logic [1:0]        hist_fill   = '0;
  logic [CountW-1:0] rep_count   = '0;
  logic              obst_held   = 1'b0;

  decision_t   expected_decisions[$];
  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;

  // sender burst control
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  // receiver stall control
  bit          hold_pending = 1'b0;
  int unsigned hold_len     = 0;
  int unsigned hold_left    = 0;
  rx_mode_e    rx_mode      = RxSteady;
  int unsigned rx_left      = 0;
  logic [7:0]  rx_pattern   = 8'hff;

  function automatic decision_t predict_decision(logic [DistW-1:0] distance,
                                                 logic [StrW-1:0] str);
    decision_t   r;
    logic        falling;
    int unsigned cnt;
    r = '0;
    if (str >= StrengthLow && str <= StrengthHigh) begin
      r.reading_accepted = 1'b1;
      falling = (hist_fill >= 2) && (distance < hist_newest) && (hist_newest < hist_prev);
      hist_prev = hist_newest;
      hist_newest = distance;
      if (hist_fill < 2) hist_fill = hist_fill + 1'b1;
      if (distance < FarDist) begin
        if (distance < thr_cfg && falling) begin
          obst_held = 1'b1;
          cnt = 32'(rep_count);
          r.send_report = (cnt < burst_cfg) ||
                          (distance > Band800 && distance < FarDist && cnt % 10 == 0) ||
                          (distance > Band500 && distance <= Band800 && cnt % 5 == 0) ||
                          (distance > Band100 && distance < Band500 && cnt % 3 == 0) ||
                          (distance <= Band100);
          rep_count = rep_count + 1'b1;
          if (rep_count == CountTop) rep_count = burst_cfg;
        end
      end else begin
        obst_held = 1'b0;
        rep_count = '0;
      end
    end
    r.obstacle_flag = obst_held;
    return r;
  endfunction

  function automatic logic [StrW-1:0] trusted_strength();
    case ($urandom_range(0, 9))
      0: return StrengthLow;
      1: return StrengthHigh;
      default: return StrW'($urandom_range(StrengthLow, StrengthHigh));
    endcase
  endfunction

  function automatic logic [StrW-1:0] rejected_strength();
    if ($urandom_range(0, 1)) return StrW'($urandom_range(0, StrengthLow - 1));
    return StrW'($urandom_range(StrengthHigh + 1, 65535));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_reading(logic [DistW-1:0] distance, logic [StrW-1:0] str);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.distance <= distance;
    req_if.strength <= str;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    expected_decisions.push_back(predict_decision(distance, str));
    @(negedge clk_i);
  endtask

  task automatic wait_for_quiet();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (expected_decisions.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgNearThr:    thr_cfg = value[ThrW-1:0];
      CfgBurstLimit: burst_cfg = value[CountW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sawtooth of falling distances with a few rejected readings mixed in
  task automatic send_descent(int unsigned n, int unsigned top);
    int unsigned d;
    d = top;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        send_reading(DistW'($urandom), rejected_strength());
      end else begin
        send_reading(DistW'(d), trusted_strength());
        if (d < 8) d = top;
        else d = d - $urandom_range(1, 6);
      end
    end
  endtask

  task automatic test_reading_window();
    send_reading(16'd0, 16'd0);
    send_reading(16'd65535, 16'd65535);
    send_reading(16'd600, StrW'(StrengthLow - 1));
    send_reading(16'd600, StrW'(StrengthHigh + 1));
    send_reading(16'd1199, StrengthLow);
    send_reading(16'd1000, StrengthHigh);
    send_reading(16'd450, 16'd100);
    send_reading(16'd450, 16'd100);
    send_reading(16'd400, 16'd100);
    send_reading(16'd300, 16'd100);
    send_reading(16'd150, 16'd100);
    send_reading(16'd120, 16'd100);
    send_reading(16'd100, 16'd100);
    send_reading(16'd200, 16'd5);
    send_reading(16'd0, 16'd1000);
    send_reading(16'd65535, 16'd500);
  endtask

  task automatic test_threshold_extremes();
    wait_for_quiet();
    write_reg(CfgNearThr, 11'd0);
    send_reading(FarDist, 16'd300);
    send_reading(16'd1150, 16'd300);
    send_reading(16'd1100, 16'd300);
    send_reading(16'd900, 16'd300);
    wait_for_quiet();
    write_reg(CfgNearThr, 11'd1200);
    write_reg(CfgBurstLimit, 11'd0);
    send_reading(16'd1199, 16'd300);
    send_reading(16'd1150, 16'd300);
    send_reading(16'd1100, 16'd300);
    send_reading(Band800, 16'd300);
    send_reading(Band500, 16'd300);
    send_reading(Band100, 16'd300);
    wait_for_quiet();
    write_reg(CfgNearThr, 11'd2047);
    write_reg(CfgBurstLimit, 11'd255);
  endtask

  // long descents so the report counter runs up to its reload point
  task automatic test_count_reload();
    for (int run = 0; run < 2; run++) begin
      wait_for_quiet();
      write_reg(CfgNearThr, run == 0 ? 11'd1200 : 11'd2047);
      write_reg(CfgBurstLimit, run == 0 ? 11'd255 : 11'($urandom_range(0, 254)));
      gaps_on = run != 0;
      send_reading(16'd65535, trusted_strength());
      if (run == 0) begin
        hold_len = 40;
        hold_pending = 1'b1;
      end
      send_descent(285, 1199);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_mixed_traffic();
    for (int phase = 0; phase < 10; phase++) begin
      wait_for_quiet();
      case ($urandom_range(0, 3))
        0: write_reg(CfgNearThr, 11'd0);
        1: write_reg(CfgNearThr, 11'd1200);
        2: write_reg(CfgNearThr, 11'd2047);
        default: write_reg(CfgNearThr, 11'($urandom_range(0, 1200)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CfgBurstLimit, 11'd0);
        1: write_reg(CfgBurstLimit, 11'd254);
        2: write_reg(CfgBurstLimit, 11'd255);
        3: write_reg(CfgBurstLimit, 11'($urandom_range(0, 2047)));
        default: write_reg(CfgBurstLimit, 11'($urandom_range(0, 20)));
      endcase
      gaps_on = $urandom_range(0, 2) != 0;
      repeat (2) begin
        case ($urandom_range(0, 4))
          0: send_reading(DistW'($urandom_range(FarDist, 65535)), trusted_strength());
          1: send_reading(DistW'($urandom), StrW'($urandom));
          default: send_descent($urandom_range(3, 6), $urandom_range(0, 1199));
        endcase
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_pending) begin
      hold_left = hold_len;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 80);
        rx_pattern = 8'($urandom_range(1, 255));
      end
      rx_left--;
      case (rx_mode)
        RxSteady: res_if.ready <= 1'b1;
        RxRandom: res_if.ready <= $urandom_range(0, 9) < 7;
        default:  res_if.ready <= rx_pattern[3'(rx_left % 8)];
      endcase
    end
  end

  always @(posedge clk_i) begin
    decision_t exp_d;
    decision_t got_d;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got_d = '{res_if.send_report, res_if.obstacle_flag, res_if.reading_accepted};
      if (expected_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending: send=%0b flag=%0b acc=%0b",
                                       got_d.send_report, got_d.obstacle_flag,
                                       got_d.reading_accepted);
      end else begin
        exp_d = expected_decisions.pop_front();
        if (got_d.send_report !== exp_d.send_report ||
            got_d.obstacle_flag !== exp_d.obstacle_flag ||
            got_d.reading_accepted !== exp_d.reading_accepted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected send=%0b flag=%0b acc=%0b, got send=%0b flag=%0b acc=%0b",
                     exp_d.send_report, exp_d.obstacle_flag, exp_d.reading_accepted,
                     got_d.send_report, got_d.obstacle_flag, got_d.reading_accepted);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgNearThr;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.distance = '0;
    req_if.strength = '0;
    res_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reading_window();
    test_threshold_extremes();
    test_count_reload();
    test_mixed_traffic();

    wait_for_quiet();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
